/* hdl/btrg_pkg.sv */
// Shared definitions for the bitmap text row generator.
// Holds operation codes, register indexes, field widths and address helpers.
// No dependencies.
package btrg_pkg;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_DRAW  = 2'd2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_CODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_COUNT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CHAR_GAP     = 3'd4;

  // Register reset values
  localparam logic [7:0] FIRST_CODE_RST   = 8'd32;
  localparam logic [8:0] GLYPH_COUNT_RST  = 9'd96;
  localparam logic [4:0] GLYPH_WIDTH_RST  = 5'd8;
  localparam logic [4:0] GLYPH_HEIGHT_RST = 5'd16;
  localparam logic [3:0] CHAR_GAP_RST     = 4'd1;

  // Store size default and drawn-area limits
  localparam int FONT_BYTES_DEF   = 4096;
  localparam int MAX_GLYPH_WIDTH  = 16;
  localparam int MAX_GLYPH_HEIGHT = 16;
  localparam int MASK_W           = 16;

  // Glyph base offset: index (8b) times row bytes (up to 4) times height (up to 31)
  localparam int STRIDE_W = 7;
  localparam int BASE_W   = 15;
  localparam int MAX_BASE = 255 * 4 * 31;
  localparam int RED_K_W  = 4;

  // Number of conditional-subtract steps that bring any base offset below f
  function automatic int red_steps(int f);
    int s;
    s = 0;
    for (int k = 0; k < 17; k++) begin
      if ((longint'(f) << k) <= longint'(MAX_BASE)) s = k + 1;
    end
    return s;
  endfunction

endpackage

/* hdl/bitmap_text_row_generator_unit.sv */
// Bitmap text row generator: glyph store, pen state and row sequencer.
// Depends on btrg_pkg.
//
// Renders centered text from a 1-bit glyph store. A load transaction writes one
// font byte, a start transaction places the pen so the string is centered and
// latches the ink color, and a draw transaction emits one result per glyph row
// (leftmost pixel in bit 0 of pixel_mask) before advancing the pen. Loads,
// starts, zero-height glyphs and codes outside the store finish in the idle
// state. A drawn glyph passes through a multiply state, S modulo steps on the
// glyph base address (3 for a 4096-byte store, 0 for a store larger than 31620
// bytes) and R rows (up to 16): rows leave at one per cycle while the output
// accepts them, each with a two-address read of the glyph store, and the output
// register lets the next transaction enter while the last row is still waiting.
// Output stalls hold the row sequencer. Clipping is left to the consumer;
// coordinates wrap at 16 bits. Store bytes are undefined until loaded.
module bitmap_text_row_generator_unit #(
  parameter int FONT_BYTES = btrg_pkg::FONT_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       operation,
  input  logic [11:0]                      font_addr,
  input  logic [7:0]                       font_byte,
  input  logic [7:0]                       string_length,
  input  logic signed [15:0]               center_x,
  input  logic signed [15:0]               center_y,
  input  logic [31:0]                      ink_color,
  input  logic [7:0]                       char_code,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [btrg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [btrg_pkg::CFG_DATA_W-1:0]  cfg_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               row_x,
  output logic signed [15:0]               row_y,
  output logic [btrg_pkg::MASK_W-1:0]      pixel_mask,
  output logic [31:0]                      pixel_color,
  output logic                             last_row
);
  import btrg_pkg::*;

  localparam int AW        = $clog2(FONT_BYTES);
  localparam int ACC_W     = (AW > BASE_W) ? AW : BASE_W;
  localparam int SUB_W     = ACC_W + 1;
  localparam int RED_STEPS = red_steps(FONT_BYTES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MULT   = 2'd1;
  localparam logic [1:0] ST_REDUCE = 2'd2;
  localparam logic [1:0] ST_ROWS   = 2'd3;

  // Configuration registers
  logic [7:0] first_code;
  logic [8:0] glyph_count;
  logic [4:0] char_width;
  logic [4:0] char_height;
  logic [3:0] char_gap;

  // Pen state
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [31:0] held_color;
  logic        drawing_active;

  // Sequencer
  logic [1:0]          state;
  logic [7:0]          char_slot;
  logic [STRIDE_W-1:0] stride;
  logic [ACC_W-1:0]    acc;
  logic [RED_K_W-1:0]  red_k;
  logic [3:0]          row_idx;
  logic [4:0]          row_total;

  // Glyph store and its read stage
  logic [7:0] glyph_mem [FONT_BYTES];
  logic [7:0] rd0;
  logic [7:0] rd1;
  logic        p1_valid;
  logic [15:0] p1_x;
  logic [15:0] p1_y;
  logic [31:0] p1_color;
  logic        p1_last;

  logic in_acc;
  logic out_free;
  logic issue;
  logic p1_move;

  logic [5:0]  advance;
  logic [13:0] str_total;
  logic [2:0]  row_bytes;
  logic [7:0]  code_off;
  logic        code_in_store;
  logic [4:0]  rows_lim;
  logic [4:0]  cols_lim;
  logic [MASK_W-1:0] col_mask;
  logic [MASK_W-1:0] mask_raw;
  logic [SUB_W-1:0]  sub_val;
  logic [AW:0]       addr1_sum;
  logic [AW-1:0]     addr0;
  logic [AW-1:0]     addr1;
  logic [AW:0]       acc_step;
  logic [AW:0]       acc_wrap;
  logic              last_issue;
  logic              load_ok;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign issue     = (state == ST_ROWS) && (!p1_valid || out_free);
  assign p1_move   = p1_valid && out_free;
  assign last_issue = (5'(row_idx) + 5'd1 == row_total);

  // Derive geometry from the configuration
  always_comb begin
    advance   = 6'(char_width) + 6'(char_gap);
    str_total = 14'(string_length * advance) - 14'(char_gap);
    row_bytes = 3'((6'(char_width) + 6'd7) >> 3);
    code_off  = char_code - first_code;
    code_in_store = (char_code >= first_code) && (9'(code_off) < glyph_count);
    rows_lim  = char_height;
    if (6'(rows_lim) > 6'(MAX_GLYPH_HEIGHT)) rows_lim = 5'(MAX_GLYPH_HEIGHT);
    if (rows_lim > 5'd16) rows_lim = 5'd16;
    cols_lim  = char_width;
    if (6'(cols_lim) > 6'(MAX_GLYPH_WIDTH)) cols_lim = 5'(MAX_GLYPH_WIDTH);
    if (cols_lim > 5'd16) cols_lim = 5'd16;
    col_mask  = MASK_W'((17'd1 << cols_lim) - 17'd1);
  end

  // Form store addresses: reduction step, row pair and next row
  always_comb begin
    sub_val   = SUB_W'(FONT_BYTES) << red_k;
    addr0     = acc[AW-1:0];
    addr1_sum = {1'b0, addr0} + (AW+1)'(1);
    addr1     = (addr1_sum == (AW+1)'(FONT_BYTES)) ? '0 : addr1_sum[AW-1:0];
    acc_step  = {1'b0, addr0} + (AW+1)'(row_bytes);
    acc_wrap  = (acc_step >= (AW+1)'(FONT_BYTES)) ?
                acc_step - (AW+1)'(FONT_BYTES) : acc_step;
    load_ok   = (17'(font_addr) < 17'(FONT_BYTES));
  end

  // Reverse each byte so the leftmost pixel lands in bit 0
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      mask_raw[c]     = rd0[7-c];
      mask_raw[c + 8] = rd1[7-c];
    end
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_code   <= FIRST_CODE_RST;
      glyph_count  <= GLYPH_COUNT_RST;
      char_width   <= GLYPH_WIDTH_RST;
      char_height  <= GLYPH_HEIGHT_RST;
      char_gap     <= CHAR_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIRST_CODE:   first_code   <= cfg_data[7:0];
        REG_GLYPH_COUNT:  glyph_count  <= cfg_data[8:0];
        REG_GLYPH_WIDTH:  char_width   <= cfg_data[4:0];
        REG_GLYPH_HEIGHT: char_height  <= cfg_data[4:0];
        REG_CHAR_GAP:     char_gap     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Sequence transactions: pen updates, base address, row loop
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pen_x          <= '0;
      pen_y          <= '0;
      held_color     <= '0;
      drawing_active <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (operation)
              OP_START: begin
                if (string_length == 8'd0) begin
                  drawing_active <= 1'b0;
                end else begin
                  pen_x          <= 16'(center_x) - 16'(str_total[13:1]);
                  pen_y          <= 16'(center_y) - 16'(char_height[4:1]);
                  held_color     <= ink_color;
                  drawing_active <= 1'b1;
                end
              end
              OP_DRAW: begin
                if (drawing_active) begin
                  if (!code_in_store) begin
                    pen_x <= pen_x + 16'(char_width);
                  end else if (rows_lim == 5'd0) begin
                    pen_x <= pen_x + 16'(advance);
                  end else begin
                    state <= ST_MULT;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_MULT: begin
          state <= (RED_STEPS == 0) ? ST_ROWS : ST_REDUCE;
        end
        ST_REDUCE: begin
          if (red_k == '0) state <= ST_ROWS;
        end
        ST_ROWS: begin
          if (issue && last_issue) begin
            pen_x <= pen_x + 16'(advance);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold glyph geometry and walk the store address
  always_ff @(posedge clk) begin
    if (in_acc) begin
      char_slot <= code_off;
      stride    <= STRIDE_W'(row_bytes * char_height);
      row_total <= rows_lim;
      row_idx   <= '0;
    end
    if (state == ST_MULT) begin
      acc   <= ACC_W'(char_slot * stride);
      red_k <= RED_K_W'(RED_STEPS - 1);
    end
    if (state == ST_REDUCE) begin
      if ({1'b0, acc} >= sub_val) acc <= ACC_W'({1'b0, acc} - sub_val);
      red_k <= red_k - RED_K_W'(1);
    end
    if (issue) begin
      acc     <= ACC_W'(acc_wrap);
      row_idx <= row_idx + 4'd1;
    end
  end

  // Write and read the glyph store
  always_ff @(posedge clk) begin
    if (in_acc && operation == OP_LOAD && load_ok) begin
      glyph_mem[AW'(font_addr)] <= font_byte;
    end
    if (issue) begin
      rd0 <= glyph_mem[addr0];
      rd1 <= glyph_mem[addr1];
    end
  end

  // Track the row in flight with its read
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (issue) begin
      p1_valid <= 1'b1;
    end else if (p1_move) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_x     <= pen_x;
      p1_y     <= pen_y + 16'(row_idx);
      p1_color <= held_color;
      p1_last  <= last_issue;
    end
  end

  // Present the result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      row_x       <= p1_x;
      row_y       <= p1_y;
      pixel_mask  <= mask_raw & col_mask;
      pixel_color <= p1_color;
      last_row    <= p1_last;
    end
  end

endmodule

/* tb/sv/tb_bitmap_text_row_generator_unit.sv */
// Self-checking testbench for bitmap_text_row_generator_unit: directed and random
// load/start/draw traffic over several font settings, rows checked against a predictor.
// Depends on btrg_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_bitmap_text_row_generator_unit;
  import btrg_pkg::*;

  // Operation code the unit must ignore
  localparam bit [1:0] OP_UNUSED = 2'd3;
  localparam int TAIL_CYCLES = 30;

  typedef struct packed {
    bit [1:0]  op;
    bit [11:0] addr;
    bit [7:0]  fbyte;
    bit [7:0]  len;
    bit [15:0] cx;
    bit [15:0] cy;
    bit [31:0] color;
    bit [7:0]  code;
  } text_cmd_t;

  typedef struct packed {
    bit [15:0] x;
    bit [15:0] y;
    bit [15:0] mask;
    bit [31:0] color;
    bit        last;
  } glyph_row_t;

  bit clk;
  bit rst = 1'b1;

  bit        in_valid;
  logic      in_ready;
  text_cmd_t cmd_drv;

  bit       cfg_valid;
  logic     cfg_ready;
  bit [2:0] cfg_index;
  bit [8:0] cfg_data;

  logic               out_valid;
  bit                 out_ready;
  logic signed [15:0] row_x;
  logic signed [15:0] row_y;
  logic [15:0]        pixel_mask;
  logic [31:0]        pixel_color;
  logic               last_row;

  // Font settings, written only while the unit is idle
  int cfg_first = FIRST_CODE_RST;
  int cfg_count = GLYPH_COUNT_RST;
  int cfg_w     = GLYPH_WIDTH_RST;
  int cfg_h     = GLYPH_HEIGHT_RST;
  int cfg_gap   = CHAR_GAP_RST;

  // Predicted unit state
  bit [7:0]  img_byte [FONT_BYTES_DEF];
  bit [15:0] cur_x;
  bit [15:0] cur_y;
  bit [31:0] ink;
  bit        text_on;

  // Bytes already scheduled for loading, so draws never touch unwritten bytes
  bit byte_loaded [FONT_BYTES_DEF];

  text_cmd_t  cmd_fifo [$];
  glyph_row_t rows_due [$];
  glyph_row_t want;

  int cmds_queued;
  int cmds_taken;
  int rows_seen;
  int settings_used;
  int fails;
  int send_gap, send_calm, recv_gap, recv_calm;

  bitmap_text_row_generator_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (cmd_drv.op),
    .font_addr    (cmd_drv.addr),
    .font_byte    (cmd_drv.fbyte),
    .string_length(cmd_drv.len),
    .center_x     (cmd_drv.cx),
    .center_y     (cmd_drv.cy),
    .ink_color    (cmd_drv.color),
    .char_code    (cmd_drv.code),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .row_x        (row_x),
    .row_y        (row_y),
    .pixel_mask   (pixel_mask),
    .pixel_color  (pixel_color),
    .last_row     (last_row)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Cycles to idle before the next transaction; occasional runs with no idling
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(8, 24);
    return $urandom_range(0, 7);
  endfunction

  function automatic int rows_drawn();
    return (cfg_h < MAX_GLYPH_HEIGHT) ? cfg_h : MAX_GLYPH_HEIGHT;
  endfunction

  function automatic int cols_drawn();
    return (cfg_w < MAX_GLYPH_WIDTH) ? cfg_w : MAX_GLYPH_WIDTH;
  endfunction

  // Store address of the byte that holds column col of row r of glyph idx
  function automatic int glyph_byte_addr(input int idx, input int r, input int col);
    int bpr;
    bpr = (cfg_w + 7) / 8;
    return (idx * bpr * cfg_h + r * bpr + col / 8) % FONT_BYTES_DEF;
  endfunction

  // Update the predicted state and queue the rows one transaction produces
  task automatic apply_cmd(input text_cmd_t c);
    int total, idx, nrows, ncols;
    glyph_row_t row;
    case (c.op)
      OP_LOAD: img_byte[c.addr] = c.fbyte;
      OP_START: begin
        if (c.len == 0) begin
          text_on = 1'b0;
        end else begin
          total = int'(c.len) * (cfg_w + cfg_gap) - cfg_gap;
          cur_x = c.cx - 16'(total / 2);
          cur_y = c.cy - 16'(cfg_h / 2);
          ink = c.color;
          text_on = 1'b1;
        end
      end
      OP_DRAW: begin
        if (text_on) begin
          idx = int'(c.code) - cfg_first;
          if (idx < 0 || idx >= cfg_count) begin
            cur_x = cur_x + 16'(cfg_w);
          end else begin
            nrows = rows_drawn();
            ncols = cols_drawn();
            for (int r = 0; r < nrows; r++) begin
              row.x = cur_x;
              row.y = cur_y + 16'(r);
              row.mask = '0;
              for (int col = 0; col < ncols; col++)
                row.mask[col] = img_byte[glyph_byte_addr(idx, r, col)][7 - col % 8];
              row.color = ink;
              row.last = (r == nrows - 1);
              rows_due.push_back(row);
            end
            cur_x = cur_x + 16'(cfg_w + cfg_gap);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Input driver: present queued transactions, idle between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_cmd(cmd_drv);
        cmds_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_fifo.size() != 0) begin
          cmd_drv <= cmd_fifo.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each row with the oldest prediction, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        rows_seen++;
        if (rows_due.size() == 0) begin
          $error("row with nothing pending: row_x %0d row_y %0d mask %h", row_x, row_y,
                 pixel_mask);
          fails++;
        end else begin
          want = rows_due.pop_front();
          if (row_x !== want.x) begin
            $error("row_x: expected %0d, got %0d", $signed(want.x), row_x);
            fails++;
          end
          if (row_y !== want.y) begin
            $error("row_y: expected %0d, got %0d", $signed(want.y), row_y);
            fails++;
          end
          if (pixel_mask !== want.mask) begin
            $error("pixel_mask: expected %h, got %h", want.mask, pixel_mask);
            fails++;
          end
          if (pixel_color !== want.color) begin
            $error("pixel_color: expected %h, got %h", want.color, pixel_color);
            fails++;
          end
          if (last_row !== want.last) begin
            $error("last_row: expected %0d, got %0d", want.last, last_row);
            fails++;
          end
        end
        recv_gap = pick_gap(recv_calm);
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
      out_ready <= (recv_gap == 0);
    end
  end

  // Transaction with every field random, op fixed
  function automatic text_cmd_t rand_cmd(input bit [1:0] op);
    text_cmd_t c;
    c.op    = op;
    c.addr  = 12'($urandom);
    c.fbyte = 8'($urandom);
    c.len   = 8'($urandom);
    c.cx    = 16'($urandom);
    c.cy    = 16'($urandom);
    c.color = $urandom;
    c.code  = 8'($urandom);
    return c;
  endfunction

  task automatic push_cmd(input text_cmd_t c);
    cmd_fifo.push_back(c);
    cmds_queued++;
  endtask

  task automatic queue_load(input int addr, input bit [7:0] value);
    text_cmd_t c;
    c = rand_cmd(OP_LOAD);
    c.addr = 12'(addr);
    c.fbyte = value;
    byte_loaded[addr] = 1'b1;
    push_cmd(c);
  endtask

  task automatic queue_start(input bit [7:0] len, input bit [15:0] cx, input bit [15:0] cy,
                             input bit [31:0] color);
    text_cmd_t c;
    c = rand_cmd(OP_START);
    c.len = len;
    c.cx = cx;
    c.cy = cy;
    c.color = color;
    push_cmd(c);
  endtask

  // Load any glyph byte the draw would read that holds no data yet, then draw
  task automatic queue_draw(input bit [7:0] code);
    int idx, a;
    text_cmd_t c;
    idx = int'(code) - cfg_first;
    if (idx >= 0 && idx < cfg_count) begin
      for (int r = 0; r < rows_drawn(); r++) begin
        for (int col = 0; col < cols_drawn(); col++) begin
          a = glyph_byte_addr(idx, r, col);
          if (!byte_loaded[a]) queue_load(a, 8'($urandom));
        end
      end
    end
    c = rand_cmd(OP_DRAW);
    c.code = code;
    push_cmd(c);
  endtask

  // Mostly codes inside the store, at its first glyphs; the rest anywhere
  function automatic bit [7:0] pick_code();
    int lim;
    lim = cfg_count;
    if (256 - cfg_first < lim) lim = 256 - cfg_first;
    if (lim > 2) lim = 2;
    if (lim > 0 && $urandom_range(0, 3) != 0)
      return 8'(cfg_first + int'($urandom_range(0, lim - 1)));
    return 8'($urandom_range(0, 255));
  endfunction

  // Hold until every transaction is taken and every row has arrived
  task automatic wait_drained();
    while (cmds_taken != cmds_queued || rows_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_font_cfg(input int fc, input int cnt, input int w, input int h,
                                input int gap);
    bit [2:0] regs [5];
    int vals [5];
    regs = '{REG_FIRST_CODE, REG_GLYPH_COUNT, REG_GLYPH_WIDTH, REG_GLYPH_HEIGHT,
             REG_CHAR_GAP};
    vals = '{fc, cnt, w, h, gap};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_index <= regs[i];
      cfg_data <= 9'(vals[i]);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cfg_first = fc;
    cfg_count = cnt;
    cfg_w = w;
    cfg_h = h;
    cfg_gap = gap;
    settings_used++;
  endtask

  // Mostly whole strings with random content, plus noise and broken sequences
  task automatic random_traffic(input int n);
    int made, k, len, ndraw;
    made = 0;
    while (made < n) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 5);
        queue_start(8'(len), 16'($urandom), 16'($urandom), $urandom);
        ndraw = (len < 6) ? len : 6;
        for (int j = 0; j < ndraw; j++) queue_draw(pick_code());
        made += 1 + ndraw;
      end else if (k < 70) begin
        queue_load($urandom_range(0, FONT_BYTES_DEF - 1), 8'($urandom));
        made++;
      end else if (k < 80) begin
        queue_start(8'd0, 16'($urandom), 16'($urandom), $urandom);
        queue_draw(pick_code());
        made += 2;
      end else if (k < 85) begin
        push_cmd(rand_cmd(OP_UNUSED));
        made++;
      end else begin
        queue_draw(8'($urandom));
        made++;
      end
      // Pause the sender now and then until the results catch up
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
  endtask

  task automatic run_setting(input int fc, input int cnt, input int w, input int h,
                             input int gap, input int n);
    write_font_cfg(fc, cnt, w, h, gap);
    random_traffic(n);
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part under reset settings
    push_cmd(rand_cmd(OP_UNUSED));
    queue_draw(8'd33);
    queue_load(0, 8'hFF);
    queue_load(FONT_BYTES_DEF - 1, 8'h00);
    queue_start(8'd1, 16'd0, 16'd0, 32'hFFFF_FFFF);
    queue_draw(8'd32);
    queue_draw(8'd127);
    queue_draw(8'd31);
    queue_draw(8'd128);
    queue_draw(8'd255);
    queue_start(8'd255, 16'h7FFF, 16'h7FFF, 32'h0000_0000);
    queue_draw(8'd33);
    queue_draw(8'd32);
    queue_start(8'd0, 16'h1234, 16'h4321, 32'h0F0F_0F0F);
    queue_draw(8'd33);
    queue_start(8'd2, 16'h8000, 16'h8000, 32'hA5A5_5A5A);
    queue_draw(8'd0);
    queue_draw(8'd127);
    push_cmd(rand_cmd(OP_UNUSED));
    wait_drained();
    random_traffic(10);
    wait_drained();

    // Extremes of the font settings, then zero width, zero height and a random one
    run_setting(0, 256, 16, 16, 15, 10);
    run_setting(255, 1, 1, 1, 0, 6);
    run_setting(200, 511, 31, 31, 7, 8);
    run_setting(10, 40, 0, 5, 3, 6);
    run_setting(64, 20, 9, 0, 2, 6);
    run_setting($urandom_range(0, 255), $urandom_range(0, 256), $urandom_range(1, 16),
                $urandom_range(1, 16), $urandom_range(0, 15), 10);

    if (rows_due.size() != 0) begin
      $error("%0d predicted rows never arrived", rows_due.size());
      fails++;
    end
    $display("covered %0d transactions over %0d written font settings plus reset values",
             cmds_taken, settings_used);
    $display("compared %0d glyph rows, %0d mismatches", rows_seen, fails);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
